// ===== hdl/twb_pkg.sv =====
// ----------------------------------------------------------------------------
// twb_pkg
// Shared types and codes of the triangle warp with bilinear RGB sampling.
// ----------------------------------------------------------------------------
`default_nettype none

package twb_pkg;

    typedef enum logic [1:0] {
        OP_PIXEL    = 2'd0,
        OP_VERTEX   = 2'd1,
        OP_TRIANGLE = 2'd2,
        OP_WARP     = 2'd3
    } t_opcode;

    localparam logic CFG_SRC_ROWS = 1'b0;
    localparam logic CFG_SRC_COLS = 1'b1;

    localparam logic [8:0] SRC_DIM_RESET = 9'd256;

    // what travels with every transaction down the pipeline
    typedef struct packed {
        t_opcode     op;
        logic [15:0] addr;
        logic        eof;
    } t_tag;

endpackage

`default_nettype wire

// ===== hdl/triangle_warp_bilinear_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_warp_bilinear_rgb_unit
// Piecewise-affine warp of a column-major RGB image with bilinear sampling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries load and warp transactions.
//   Pixel, vertex and triangle loads fill three stores; a warp transaction
//   produces one result on the output channel (o_out_valid / i_out_stall),
//   loads produce none. Results leave in input order.
//   Throughput: one transaction per cycle unless stalled. Each store is
//   written at the same pipeline stage where warps read it, so order is
//   kept without forwarding. The four neighbor pixels come from four
//   image RAM copies.
//   Stall: the pipeline freezes (o_in_stall high) only while a result sits
//   in the output register and the receiver stalls.
//   Reset: clears pipeline valids and sets src_rows = src_cols = 256. The
//   stores are not cleared; they must be loaded before use.
//   Config: write src_rows/src_cols via i_cfg_we while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_warp_bilinear_rgb_unit
    import twb_pkg::*;
#(
    parameter int MAX_PIXELS    = 65536,
    parameter int MAX_VERTICES  = 128,
    parameter int MAX_TRIANGLES = 256
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire                i_cfg_index,
    input  wire  [8:0]         i_cfg_data,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  [1:0]         i_opcode,
    input  wire  [15:0]        i_address,
    input  wire  signed [19:0] i_value_a,
    input  wire  signed [19:0] i_value_b,
    input  wire  signed [19:0] i_value_c,
    input  wire  signed [15:0] i_alpha,
    input  wire  signed [15:0] i_beta,
    input  wire  signed [15:0] i_gamma,
    input  wire                i_end_of_frame,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic [15:0]        o_dest_index,
    output logic [7:0]         o_red_out,
    output logic [7:0]         o_green_out,
    output logic [7:0]         o_blue_out,
    output logic               o_in_range,
    output logic               o_frame_done
);

    localparam int TW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int VW = $clog2(MAX_VERTICES);
    localparam int PW = $clog2(MAX_PIXELS);

    function automatic logic [VW-1:0] vert_idx(input logic [19:0] v);
        if (32'(v) >= MAX_VERTICES) begin
            vert_idx = VW'(MAX_VERTICES - 1);
        end else begin
            vert_idx = VW'(v);
        end
    endfunction

    logic en, acc;
    logic [8:0]  r_rows, r_cols;
    logic [20:0] r_lim;
    logic [17:0] area;

    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;
    assign acc        = i_in_valid && en;
    assign area       = r_rows * r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= SRC_DIM_RESET;
            r_cols <= SRC_DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SRC_ROWS: r_rows <= i_cfg_data;
                CFG_SRC_COLS: r_cols <= i_cfg_data;
                default: ;
            endcase
        end
        if (32'(area) > MAX_PIXELS) begin
            r_lim <= 21'(MAX_PIXELS);
        end else begin
            r_lim <= 21'(area);
        end
    end

    // stage 1: triangle read done
    logic               r1_v, r1_bad;
    t_tag               r1_tag;
    logic signed [19:0] r1_a, r1_b, r1_c;
    logic signed [15:0] r1_al, r1_be, r1_ga;
    logic [3*VW-1:0]    tri_q;

    twb_ram #(.W(3*VW), .D(MAX_TRIANGLES)) u_tri (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_we    (acc && i_opcode == OP_TRIANGLE && 32'(i_address) < MAX_TRIANGLES),
        .i_waddr (TW'(32'(i_address))),
        .i_wdata ({vert_idx(i_value_c), vert_idx(i_value_b), vert_idx(i_value_a)}),
        .i_raddr (TW'(i_value_a)),
        .o_rdata (tri_q)
    );

    // stage 2: vertex reads done
    logic               r2_v, r2_bad;
    t_tag               r2_tag;
    logic [23:0]        r2_pix;
    logic signed [15:0] r2_al, r2_be, r2_ga;
    logic [39:0]        vq1, vq2, vq3;
    logic               vtx_we;

    assign vtx_we = r1_v && r1_tag.op == OP_VERTEX && 32'(r1_tag.addr) < MAX_VERTICES;

    twb_ram #(.W(40), .D(MAX_VERTICES)) u_vtx1 (
        .i_clk(i_clk), .i_en(en), .i_we(vtx_we), .i_waddr(VW'(r1_tag.addr)),
        .i_wdata({r1_b, r1_a}), .i_raddr(tri_q[VW-1:0]), .o_rdata(vq1)
    );
    twb_ram #(.W(40), .D(MAX_VERTICES)) u_vtx2 (
        .i_clk(i_clk), .i_en(en), .i_we(vtx_we), .i_waddr(VW'(r1_tag.addr)),
        .i_wdata({r1_b, r1_a}), .i_raddr(tri_q[2*VW-1:VW]), .o_rdata(vq2)
    );
    twb_ram #(.W(40), .D(MAX_VERTICES)) u_vtx3 (
        .i_clk(i_clk), .i_en(en), .i_we(vtx_we), .i_waddr(VW'(r1_tag.addr)),
        .i_wdata({r1_b, r1_a}), .i_raddr(tri_q[3*VW-1:2*VW]), .o_rdata(vq3)
    );

    // stage 3: products
    logic               r3_v, r3_bad;
    t_tag               r3_tag;
    logic [23:0]        r3_pix;
    logic signed [35:0] r3_px1, r3_px2, r3_px3, r3_py1, r3_py2, r3_py3;

    // stage 4: integer and fraction
    logic               r4_v, r4_bad;
    t_tag               r4_tag;
    logic [23:0]        r4_pix;
    logic signed [15:0] r4_ix, r4_iy;
    logic [7:0]         r4_fx, r4_fy;
    logic signed [37:0] sx, sy;

    assign sx = 38'(r3_px1) + 38'(r3_px2) + 38'(r3_px3);
    assign sy = 38'(r3_py1) + 38'(r3_py2) + 38'(r3_py3);

    // stage 5: column offset
    logic               r5_v, r5_bad;
    t_tag               r5_tag;
    logic [23:0]        r5_pix;
    logic signed [25:0] r5_prod;
    logic signed [15:0] r5_iy;
    logic [7:0]         r5_fx, r5_fy;

    // stage 5 logic: neighbor indices, range check, image reads
    logic signed [26:0] i1;
    logic signed [27:0] i4;
    logic               inr;
    logic               pix_we;
    logic [PW-1:0]      a1, a2, a3, a4;

    assign i1  = 27'(r5_prod) + 27'(r5_iy);
    assign i4  = 28'(i1) + 28'(r_rows) + 28'sd1;
    assign inr = !r5_bad && !i1[26] && (i4 < $signed({7'b0, r_lim}));
    assign a1  = PW'(i1);
    assign a3  = PW'(i1 + 27'sd1);
    assign a2  = PW'(i1 + 27'(r_rows));
    assign a4  = PW'(i4);
    assign pix_we = r5_v && r5_tag.op == OP_PIXEL && 32'(r5_tag.addr) < MAX_PIXELS;

    logic [23:0] p1, p2, p3, p4;

    twb_ram #(.W(24), .D(MAX_PIXELS)) u_img1 (
        .i_clk(i_clk), .i_en(en), .i_we(pix_we), .i_waddr(PW'(32'(r5_tag.addr))),
        .i_wdata(r5_pix), .i_raddr(a1), .o_rdata(p1)
    );
    twb_ram #(.W(24), .D(MAX_PIXELS)) u_img2 (
        .i_clk(i_clk), .i_en(en), .i_we(pix_we), .i_waddr(PW'(32'(r5_tag.addr))),
        .i_wdata(r5_pix), .i_raddr(a2), .o_rdata(p2)
    );
    twb_ram #(.W(24), .D(MAX_PIXELS)) u_img3 (
        .i_clk(i_clk), .i_en(en), .i_we(pix_we), .i_waddr(PW'(32'(r5_tag.addr))),
        .i_wdata(r5_pix), .i_raddr(a3), .o_rdata(p3)
    );
    twb_ram #(.W(24), .D(MAX_PIXELS)) u_img4 (
        .i_clk(i_clk), .i_en(en), .i_we(pix_we), .i_waddr(PW'(32'(r5_tag.addr))),
        .i_wdata(r5_pix), .i_raddr(a4), .o_rdata(p4)
    );

    // stage 6: pixels and weights
    logic        r6_v, r6_in;
    t_tag        r6_tag;
    logic [16:0] r6_w1, r6_w2, r6_w3, r6_w4;
    logic [8:0]  nfx, nfy;

    assign nfx = 9'd256 - 9'(r5_fx);
    assign nfy = 9'd256 - 9'(r5_fy);

    // stage 7: channel products, index 0 red, 1 green, 2 blue
    logic        r7_v, r7_in;
    t_tag        r7_tag;
    logic [24:0] r7_q1 [3];
    logic [24:0] r7_q2 [3];
    logic [24:0] r7_q3 [3];
    logic [24:0] r7_q4 [3];
    logic [25:0] sum   [3];
    logic [9:0]  rnd   [3];
    logic [7:0]  chan  [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k]  = 26'(r7_q1[k]) + 26'(r7_q2[k]) + 26'(r7_q3[k]) + 26'(r7_q4[k])
                      + 26'd32768;
            rnd[k]  = sum[k][25:16];
            chan[k] = (rnd[k] > 10'd255) ? 8'd255 : rnd[k][7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r4_v        <= 1'b0;
            r5_v        <= 1'b0;
            r6_v        <= 1'b0;
            r7_v        <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r1_v        <= i_in_valid;
            r2_v        <= r1_v;
            r3_v        <= r2_v;
            r4_v        <= r3_v;
            r5_v        <= r4_v;
            r6_v        <= r5_v;
            r7_v        <= r6_v;
            o_out_valid <= r7_v && r7_tag.op == OP_WARP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_tag <= '{op: t_opcode'(i_opcode), addr: i_address, eof: i_end_of_frame};
            r1_bad <= 32'($unsigned(i_value_a)) >= MAX_TRIANGLES;
            r1_a   <= i_value_a;
            r1_b   <= i_value_b;
            r1_c   <= i_value_c;
            r1_al  <= i_alpha;
            r1_be  <= i_beta;
            r1_ga  <= i_gamma;

            r2_tag <= r1_tag;
            r2_bad <= r1_bad;
            r2_pix <= {r1_c[7:0], r1_b[7:0], r1_a[7:0]};
            r2_al  <= r1_al;
            r2_be  <= r1_be;
            r2_ga  <= r1_ga;

            r3_tag <= r2_tag;
            r3_bad <= r2_bad;
            r3_pix <= r2_pix;
            r3_px1 <= $signed(vq1[19:0])  * r2_ga;
            r3_px2 <= $signed(vq2[19:0])  * r2_al;
            r3_px3 <= $signed(vq3[19:0])  * r2_be;
            r3_py1 <= $signed(vq1[39:20]) * r2_ga;
            r3_py2 <= $signed(vq2[39:20]) * r2_al;
            r3_py3 <= $signed(vq3[39:20]) * r2_be;

            r4_tag <= r3_tag;
            r4_bad <= r3_bad;
            r4_pix <= r3_pix;
            r4_ix  <= sx[37:22];
            r4_iy  <= sy[37:22];
            r4_fx  <= sx[21:14];
            r4_fy  <= sy[21:14];

            r5_tag  <= r4_tag;
            r5_bad  <= r4_bad;
            r5_pix  <= r4_pix;
            r5_prod <= 26'(r4_ix * $signed({1'b0, r_rows}));
            r5_iy   <= r4_iy;
            r5_fx   <= r4_fx;
            r5_fy   <= r4_fy;

            r6_tag <= r5_tag;
            r6_in  <= inr;
            r6_w1  <= nfx * nfy;
            r6_w2  <= 17'(r5_fx) * 17'(nfy);
            r6_w3  <= 17'(nfx) * 17'(r5_fy);
            r6_w4  <= 17'(r5_fx) * 17'(r5_fy);

            r7_tag <= r6_tag;
            r7_in  <= r6_in;
            for (int k = 0; k < 3; k++) begin
                r7_q1[k] <= r6_w1 * p1[8*k +: 8];
                r7_q2[k] <= r6_w2 * p2[8*k +: 8];
                r7_q3[k] <= r6_w3 * p3[8*k +: 8];
                r7_q4[k] <= r6_w4 * p4[8*k +: 8];
            end

            o_dest_index <= r7_tag.addr;
            o_frame_done <= r7_tag.eof;
            o_in_range   <= r7_in;
            o_red_out    <= r7_in ? chan[0] : 8'd0;
            o_green_out  <= r7_in ? chan[1] : 8'd0;
            o_blue_out   <= r7_in ? chan[2] : 8'd0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/twb_ram.sv =====
// ----------------------------------------------------------------------------
// twb_ram
// Generic single-write, single-read RAM with registered read data. Reads
// return the old contents on a same-cycle write. The enable holds the port.
// ----------------------------------------------------------------------------
`default_nettype none

module twb_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire                         i_clk,
    input  wire                         i_en,
    input  wire                         i_we,
    input  wire  [(D > 1 ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire  [W-1:0]                i_wdata,
    input  wire  [(D > 1 ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                o_rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                mem[i_waddr] <= i_wdata;
            end
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/twb_checker.sv =====
// ----------------------------------------------------------------------------
// twb_checker
// Port-level checks of the triangle warp unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module twb_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_stall,
    input wire       o_in_stall,
    input wire       o_out_valid,
    input wire [7:0] o_red_out,
    input wire [7:0] o_green_out,
    input wire [7:0] o_blue_out,
    input wire       o_in_range
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_range |->
            o_red_out == 8'd0 && o_green_out == 8'd0 && o_blue_out == 8'd0)
        else $error("out-of-range result has nonzero channels");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output back-pressure");

endmodule

bind triangle_warp_bilinear_rgb_unit twb_checker u_twb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_stall (i_out_stall),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out),
    .o_in_range  (o_in_range)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of triangle_warp_bilinear_rgb_unit.
// Drives pixel, vertex, triangle and warp transactions with random gaps and
// receiver stalls. A scoreboard class mirrors the stores and registers,
// predicts the blended pixel of every warp and checks results in order.
// Warps are preceded by the loads they depend on, so no warp result depends
// on an unwritten entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import twb_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLD_CYCLES    = 200;

    typedef struct {
        t_opcode            op;
        logic [15:0]        addr;
        logic signed [19:0] a, b, c;
        logic signed [15:0] al, be, ga;
        logic               eof;
    } t_warp_item;

    typedef struct {
        logic [15:0] dest;
        logic [7:0]  red, green, blue;
        logic        in_range, done;
    } t_pixel_result;

    class t_warp_scoreboard;
        bit [23:0]     img [65536];
        bit            pix_written [65536];
        int            vx [128];
        int            vy [128];
        bit            vert_written [128];
        int            tri_vert [256][3];
        bit            tri_written [256];
        int            rows = 256;
        int            cols = 256;
        t_pixel_result expected_pixels [$];
        int            errors = 0;

        function void report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endfunction

        function int cap_vertex(logic [19:0] v);
            return (v >= 128) ? 127 : int'(v);
        endfunction

        // maps a warp onto the four neighbor indices; 1 when all are inside
        function bit locate(t_warp_item it, output int idx[4], output int fx, output int fy);
            logic [19:0] t;
            int v1, v2, v3;
            longint sx, sy, tx, ty, ix, iy, lim, i1, i2;
            t = it.a;
            fx = 0;
            fy = 0;
            idx = '{default: 0};
            if (t >= 256) return 0;
            v1 = tri_vert[t][0];
            v2 = tri_vert[t][1];
            v3 = tri_vert[t][2];
            sx = longint'(vx[v1]) * longint'(it.ga) + longint'(vx[v2]) * longint'(it.al)
               + longint'(vx[v3]) * longint'(it.be);
            sy = longint'(vy[v1]) * longint'(it.ga) + longint'(vy[v2]) * longint'(it.al)
               + longint'(vy[v3]) * longint'(it.be);
            tx = sx >>> 14;
            ty = sy >>> 14;
            ix = tx >>> 8;
            iy = ty >>> 8;
            fx = int'(tx & 255);
            fy = int'(ty & 255);
            lim = longint'(rows) * longint'(cols);
            if (lim > 65536) lim = 65536;
            i1 = iy + ix * rows;
            i2 = iy + (ix + 1) * rows;
            if (i1 < 0 || i1 + 1 >= lim || i2 < 0 || i2 + 1 >= lim) return 0;
            idx[0] = int'(i1);
            idx[1] = int'(i2);
            idx[2] = int'(i1 + 1);
            idx[3] = int'(i2 + 1);
            return 1;
        endfunction

        function void note_input(t_warp_item it);
            t_pixel_result r;
            int idx[4];
            int fx, fy, sh;
            longint acc;
            longint w[4];
            case (it.op)
                OP_PIXEL: begin
                    img[it.addr] = {it.c[7:0], it.b[7:0], it.a[7:0]};
                    pix_written[it.addr] = 1;
                end
                OP_VERTEX: if (it.addr < 128) begin
                    vx[it.addr] = it.a;
                    vy[it.addr] = it.b;
                    vert_written[it.addr] = 1;
                end
                OP_TRIANGLE: if (it.addr < 256) begin
                    tri_vert[it.addr][0] = cap_vertex(it.a);
                    tri_vert[it.addr][1] = cap_vertex(it.b);
                    tri_vert[it.addr][2] = cap_vertex(it.c);
                    tri_written[it.addr] = 1;
                end
                default: begin
                    r = '{dest: it.addr, red: 0, green: 0, blue: 0, in_range: 0, done: it.eof};
                    if (locate(it, idx, fx, fy)) begin
                        w[0] = (256 - fx) * (256 - fy);
                        w[1] = fx * (256 - fy);
                        w[2] = (256 - fx) * fy;
                        w[3] = fx * fy;
                        for (int ch = 0; ch < 3; ch++) begin
                            sh = ch * 8;
                            acc = 0;
                            for (int k = 0; k < 4; k++)
                                acc += w[k] * ((img[idx[k]] >> sh) & 8'hFF);
                            acc = (acc + 32768) >> 16;
                            if (acc > 255) acc = 255;
                            if (ch == 0) r.red = acc[7:0];
                            else if (ch == 1) r.green = acc[7:0];
                            else r.blue = acc[7:0];
                        end
                        r.in_range = 1;
                    end
                    expected_pixels.push_back(r);
                end
            endcase
        endfunction

        function void check_result(t_pixel_result got);
            t_pixel_result e;
            if (expected_pixels.size() == 0) begin
                report($sformatf("unexpected result dest %0d", got.dest));
                return;
            end
            e = expected_pixels.pop_front();
            if (got.dest !== e.dest)
                report($sformatf("dest_index %0d, want %0d", got.dest, e.dest));
            if (got.red !== e.red)
                report($sformatf("red_out %0d, want %0d (dest %0d)", got.red, e.red, e.dest));
            if (got.green !== e.green)
                report($sformatf("green_out %0d, want %0d (dest %0d)", got.green, e.green,
                                 e.dest));
            if (got.blue !== e.blue)
                report($sformatf("blue_out %0d, want %0d (dest %0d)", got.blue, e.blue, e.dest));
            if (got.in_range !== e.in_range)
                report($sformatf("in_range %0b, want %0b (dest %0d)", got.in_range, e.in_range,
                                 e.dest));
            if (got.done !== e.done)
                report($sformatf("frame_done %0b, want %0b (dest %0d)", got.done, e.done,
                                 e.dest));
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [8:0]         i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_opcode;
    logic [15:0]        i_address;
    logic signed [19:0] i_value_a, i_value_b, i_value_c;
    logic signed [15:0] i_alpha, i_beta, i_gamma;
    logic               i_end_of_frame;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [15:0]        o_dest_index;
    logic [7:0]         o_red_out, o_green_out, o_blue_out;
    logic               o_in_range, o_frame_done;

    t_warp_scoreboard sb;
    int               gap_max;
    bit               hold_req;
    int               idle_count;

    triangle_warp_bilinear_rgb_unit dut (.*);

    initial i_clk = 0;
    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result('{o_dest_index, o_red_out, o_green_out, o_blue_out,
                              o_in_range, o_frame_done});
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stall before each result, one long hold on request
    initial begin
        int w;
        i_out_stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_stall = 1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 0;
                i_out_stall = 0;
            end else begin
                w = $urandom_range(0, gap_max);
                if (w > 0) begin
                    i_out_stall = 1;
                    repeat (w) @(negedge i_clk);
                    i_out_stall = 0;
                end
                do @(posedge i_clk); while (!o_out_valid);
            end
        end
    end

    function automatic t_warp_item mk(t_opcode op, logic [15:0] addr,
                                      logic signed [19:0] a, b, c,
                                      logic signed [15:0] al, be, ga, logic eof);
        t_warp_item it;
        it = '{op, addr, a, b, c, al, be, ga, eof};
        return it;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send(t_warp_item it);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_in_valid = 0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode       = it.op;
        i_address      = it.addr;
        i_value_a      = it.a;
        i_value_b      = it.b;
        i_value_c      = it.c;
        i_alpha        = it.al;
        i_beta         = it.be;
        i_gamma        = it.ga;
        i_end_of_frame = it.eof;
        i_in_valid     = 1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
        @(negedge i_clk);
    endtask

    task automatic load_pixel(int addr);
        send(mk(OP_PIXEL, addr[15:0], 20'($urandom), 20'($urandom), 20'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom)));
    endtask

    task automatic load_vertex(int v);
        int re, ce;
        logic signed [19:0] x, y;
        re = (sb.rows == 0) ? 1 : (sb.rows > 256 ? 256 : sb.rows);
        ce = (sb.cols == 0) ? 1 : (sb.cols > 256 ? 256 : sb.cols);
        if ($urandom_range(0, 9) == 0) begin
            x = 20'($urandom);
            y = 20'($urandom);
        end else begin
            x = 20'($urandom_range(0, ce * 256 - 1));
            y = 20'($urandom_range(0, re * 256 - 1));
        end
        send(mk(OP_VERTEX, v[15:0], x, y, 20'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 1'($urandom)));
    endtask

    task automatic load_triangle(int t);
        logic signed [19:0] v [3];
        foreach (v[k])
            v[k] = ($urandom_range(0, 9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 47));
        send(mk(OP_TRIANGLE, t[15:0], v[0], v[1], v[2], 16'($urandom), 16'($urandom),
                16'($urandom), 1'($urandom)));
    endtask

    // issues the loads a warp depends on, then the warp itself
    task automatic warp_at(logic [19:0] t, logic signed [15:0] al, be, ga, logic eof);
        t_warp_item it;
        int idx[4];
        int fx, fy;
        it = mk(OP_WARP, 16'($urandom), t, 20'($urandom), 20'($urandom), al, be, ga, eof);
        if (t < 256) begin
            if (!sb.tri_written[t]) load_triangle(t);
            for (int k = 0; k < 3; k++)
                if (!sb.vert_written[sb.tri_vert[t][k]]) load_vertex(sb.tri_vert[t][k]);
            if (sb.locate(it, idx, fx, fy))
                foreach (idx[k])
                    if (!sb.pix_written[idx[k]]) load_pixel(idx[k]);
        end
        send(it);
    endtask

    task automatic random_warp();
        logic [19:0] t;
        int a, b;
        t = 20'($urandom_range(0, 31));
        if ($urandom_range(0, 9) == 0) load_triangle(t);
        else if ($urandom_range(0, 19) == 0)
            load_vertex(sb.tri_vert[t][$urandom_range(0, 2)]);
        a = $urandom_range(0, 16384);
        b = $urandom_range(0, 16384 - a);
        warp_at(t, a[15:0], b[15:0], 16'(16384 - a - b), $urandom_range(0, 7) == 0);
    endtask

    task automatic noise_item();
        int addr;
        case ($urandom_range(0, 3))
            0: load_pixel($urandom);
            1: begin
                addr = $urandom_range(0, 1) ? $urandom_range(0, 127) : $urandom_range(0, 65535);
                send(mk(OP_VERTEX, addr[15:0], 20'($urandom), 20'($urandom), 20'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom)));
            end
            2: begin
                addr = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 65535);
                send(mk(OP_TRIANGLE, addr[15:0], 20'($urandom), 20'($urandom), 20'($urandom),
                        16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom)));
            end
            default:
                warp_at($urandom_range(0, 1) ? 20'($urandom) : 20'($urandom_range(0, 255)),
                        16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
        endcase
    endtask

    task automatic write_cfg(logic idx, logic [8:0] data);
        i_cfg_we    = 1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(negedge i_clk);
        i_cfg_we = 0;
        if (idx == CFG_SRC_ROWS) sb.rows = data;
        else sb.cols = data;
    endtask

    task automatic wait_idle();
        i_in_valid = 0;
        while (sb.expected_pixels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    int cfg_rows [6] = '{256, 16, 1, 0, 511, 3};
    int cfg_cols [6] = '{256, 20, 1, 300, 511, 7};

    initial begin
        sb = new();
        gap_max        = 0;
        hold_req       = 0;
        idle_count     = 0;
        i_rst_n        = 0;
        i_cfg_we       = 0;
        i_cfg_index    = CFG_SRC_ROWS;
        i_cfg_data     = 0;
        i_in_valid     = 0;
        i_opcode       = OP_PIXEL;
        i_address      = 0;
        i_value_a      = 0;
        i_value_b      = 0;
        i_value_c      = 0;
        i_alpha        = 0;
        i_beta         = 0;
        i_gamma        = 0;
        i_end_of_frame = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: field extremes, ignored loads, bad triangles, edge points
        send(mk(OP_PIXEL, 16'hFFFF, 20'h7FFFF, -20'sd524288, 20'h000FF, 0, 0, 0, 0));
        send(mk(OP_VERTEX, 16'd128, 20'h12345, 20'h54321, 0, 0, 0, 0, 0));
        send(mk(OP_VERTEX, 16'hFFFF, 20'h7FFFF, 20'h7FFFF, 0, 0, 0, 0, 0));
        send(mk(OP_VERTEX, 16'd127, -20'sd524288, 20'sd524287, 0, 0, 0, 0, 0));
        send(mk(OP_VERTEX, 16'd0, 0, 0, 0, 0, 0, 0, 0));
        send(mk(OP_VERTEX, 16'd1, 20'(254 * 256 + 255), 0, 0, 0, 0, 0, 0));
        send(mk(OP_VERTEX, 16'd2, 0, 20'(254 * 256 + 255), 0, 0, 0, 0, 0));
        send(mk(OP_TRIANGLE, 16'd256, 1, 2, 3, 0, 0, 0, 0));
        send(mk(OP_TRIANGLE, 16'd255, -20'sd1, 20'h80000, 20'd128, 0, 0, 0, 0));
        send(mk(OP_TRIANGLE, 16'd0, 0, 1, 2, 0, 0, 0, 0));
        warp_at(20'hFFFFF, 0, 0, 16'sd16384, 0);
        warp_at(20'd256, 0, 0, 16'sd16384, 1);
        warp_at(20'd255, 16'sd16384, 0, 0, 0);
        warp_at(0, 0, 0, 16'sd16384, 0);
        warp_at(0, 16'sd16384, 0, 0, 0);
        warp_at(0, 0, 16'sd16384, 0, 0);
        warp_at(0, 16'sd8191, 16'sd8191, 16'sd2, 0);
        warp_at(0, 16'sd32767, 16'sd32767, 16'sd32767, 0);
        warp_at(0, -16'sd32768, 0, 16'sd16384, 0);
        warp_at(0, 0, -16'sd32768, -16'sd32768, 1);

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            write_cfg(CFG_SRC_ROWS, 9'(cfg_rows[ph]));
            write_cfg(CFG_SRC_COLS, 9'(cfg_cols[ph]));
            gap_max = (ph % 2) ? 16 : 0;
            if (ph == 2) hold_req = 1;
            for (int n = 0; n < 40; n++) begin
                if ($urandom_range(0, 6) == 0) noise_item();
                else random_warp();
            end
        end

        i_in_valid = 0;
        while (sb.expected_pixels.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (sb.expected_pixels.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_pixels.size()));
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/twb_pkg.sv
hdl/twb_ram.sv
hdl/triangle_warp_bilinear_rgb_unit.sv
hdl/twb_checker.sv
tb/tb.sv
